### src/dual_sine_cv_oscillator_defines.svh
// ---------------------------------------------------------------------------
// dual_sine_cv_oscillator_defines.svh
// Assertion macros shared by the oscillator RTL.
// ---------------------------------------------------------------------------
`ifndef DUAL_SINE_CV_OSCILLATOR_DEFINES_SVH
`define DUAL_SINE_CV_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DSCO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DSCO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dsco_pkg.sv
// ---------------------------------------------------------------------------
// dsco_pkg
// Shared widths, codes, reset values and the quarter-wave sine generator.
// ---------------------------------------------------------------------------
`default_nettype none

package dsco_pkg;

  // field widths
  localparam int CMD_W    = 1;
  localparam int AXIS_W   = 3;
  localparam int VALUE_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;
  localparam int GAIN_W   = 16;

  // default build
  localparam int DEF_TABLE_ADDR_BITS = 10;
  localparam int DEF_OUT_BITS        = 16;

  // config port
  localparam int                CFG_ADDR_W         = 2;
  localparam int                CFG_DATA_W         = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_FREQ_GAIN = 2'd0;

  // item codes
  localparam logic [CMD_W-1:0]  CMD_TICK = 1'b0;
  localparam logic [CMD_W-1:0]  CMD_AXIS = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_STEP_ONE = 3'd0;
  localparam logic [AXIS_W-1:0] AXIS_GAIN_TWO = 3'd1;
  localparam logic [AXIS_W-1:0] AXIS_STEP_TWO = 3'd3;
  localparam logic [AXIS_W-1:0] AXIS_GAIN_ONE = 3'd4;

  // reset values
  localparam logic [CFG_DATA_W-1:0] FREQ_GAIN_RST = 32'd1789637;
  localparam logic [PHASE_W-1:0]    STEP_RST      = 32'd39370534;
  localparam logic signed [GAIN_W-1:0] GAIN_RST   = 16'sd16384;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  // sin(pi/2 * q / 2^(tab_bits-2)) scaled by 2^(out_bits-1)-1, truncating
  // Q30 Horner series to x^9, rounded at the end. Elaboration only.
  function automatic logic [63:0] quarter_sine(input logic [63:0] q,
                                               input int tab_bits,
                                               input int out_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] peak;
    peak = (64'd1 << (out_bits - 1)) - 64'd1;
    x  = (q * HALF_PI_Q30) >> (tab_bits - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    t  = (x * t) >> 30;
    return (t * peak + (Q30_ONE >> 1)) >> 30;
  endfunction

endpackage

`default_nettype wire

### src/dsco_if.sv
// ---------------------------------------------------------------------------
// dsco_if
// Valid/ready channels: command items in, sample pairs out.
// ---------------------------------------------------------------------------
`default_nettype none

interface dsco_in_if;
  logic                              valid;
  logic                              ready;
  logic [dsco_pkg::CMD_W-1:0]        cmd;
  logic [dsco_pkg::AXIS_W-1:0]       axis_number;
  logic signed [dsco_pkg::VALUE_W-1:0] axis_value;

  modport source (output valid, cmd, axis_number, axis_value, input ready);
  modport sink   (input valid, cmd, axis_number, axis_value, output ready);
endinterface

interface dsco_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dsco_pkg::SAMPLE_W-1:0] sample_one;
  logic signed [dsco_pkg::SAMPLE_W-1:0] sample_two;

  modport source (output valid, sample_one, sample_two, input ready);
  modport sink   (input valid, sample_one, sample_two, output ready);
endinterface

`default_nettype wire

### src/dual_sine_cv_oscillator.sv
// ---------------------------------------------------------------------------
// dual_sine_cv_oscillator
// Two-channel sine NCO: phase accumulators, quarter-wave ROM, gain scaling.
// ---------------------------------------------------------------------------
// Usage:
//  in_chan  : one item per handshake. cmd = tick advances both phases and
//             yields one sample pair; cmd = axis loads a step or a gain from
//             axis_value (axis 0 / 3 step one / two, axis 4 / 1 gain one /
//             two), other axes are dropped. Axis items give no result.
//  out_chan : sample_one / sample_two, Q1.15, one pair per tick.
//  cfg_*    : APB write/read of freq_gain at address 0; always ready.
//             Write only while the block is idle.
//  Throughput: one item per cycle while in_chan.ready is high. A tick's
//  pair is registered through phase add, ROM read, multiply and round in
//  turn before out_chan.valid rises.
//  Stall: four stages each hold one tick and collapse bubbles, so input is
//  still taken while a finished pair waits; in_chan.ready drops only once
//  every stage is full and out_chan.ready is low.
//  Reset (rst_n low, synchronous): phases 0, steps 440 Hz at 48 kHz, gains
//  one half, freq_gain to its default, pipeline emptied.
// ---------------------------------------------------------------------------
`default_nettype none
`include "dual_sine_cv_oscillator_defines.svh"

module dual_sine_cv_oscillator #(
  parameter int TABLE_ADDR_BITS = dsco_pkg::DEF_TABLE_ADDR_BITS,
  parameter int OUT_BITS        = dsco_pkg::DEF_OUT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dsco_in_if.sink                              in_chan,
  dsco_out_if.source                           out_chan,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [dsco_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [dsco_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [dsco_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
  localparam int IDX_W   = TABLE_ADDR_BITS - 1;   // holds 0..QUARTER
  // series overshoots the peak slightly, so one bit of headroom
  localparam int MAG_W   = OUT_BITS;
  localparam int PROD_W  = dsco_pkg::GAIN_W + OUT_BITS + 1;
  localparam int PW      = dsco_pkg::PHASE_W;
  localparam int GW      = dsco_pkg::GAIN_W;
  localparam int VW      = dsco_pkg::VALUE_W;
  localparam int SW      = dsco_pkg::SAMPLE_W;

  // ---- config register ----------------------------------------------------
  logic [dsco_pkg::CFG_DATA_W-1:0] freq_gain_r;
  logic                            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == dsco_pkg::CFG_ADDR_FREQ_GAIN) ? freq_gain_r
                                                                 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_gain_r <= dsco_pkg::FREQ_GAIN_RST;
    end else if (cfg_wr && cfg_paddr == dsco_pkg::CFG_ADDR_FREQ_GAIN) begin
      freq_gain_r <= cfg_pwdata;
    end
  end

  // ---- pipeline enables (bubble collapsing) -------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic en1, en2, en3, en_out;

  assign en_out = !out_vld_r || out_chan.ready;
  assign en3    = !s3_vld_r  || en_out;
  assign en2    = !s2_vld_r  || en3;
  assign en1    = !s1_vld_r  || en2;

  assign in_chan.ready = en1;

  logic in_acc, tick_acc, axis_acc;
  assign in_acc   = in_chan.valid && en1;
  assign tick_acc = in_acc && (in_chan.cmd == dsco_pkg::CMD_TICK);
  assign axis_acc = in_acc && (in_chan.cmd == dsco_pkg::CMD_AXIS);

  // ---- axis decode ----------------------------------------------------------
  // step = clamp0(v + 32767) * freq_gain >> 16; the clamp only bites at -32768
  logic signed [VW:0]   axis_sum;
  logic [VW-1:0]        axis_pos;
  logic [VW+PW-1:0]     axis_prod;
  logic [PW-1:0]        axis_step;
  logic signed [GW-1:0] axis_gain;

  assign axis_sum  = {in_chan.axis_value[VW-1], in_chan.axis_value}
                   + (VW+1)'(signed'(32767));
  assign axis_pos  = axis_sum[VW] ? '0 : axis_sum[VW-1:0];
  assign axis_prod = (VW+PW)'(axis_pos) * (VW+PW)'(freq_gain_r);
  assign axis_step = axis_prod[VW+PW-1:VW];
  // negation saturates for the most negative value
  assign axis_gain = (in_chan.axis_value == {1'b1, {(VW-1){1'b0}}})
                   ? {1'b0, {(GW-1){1'b1}}}
                   : GW'(-in_chan.axis_value);

  // ---- channel state --------------------------------------------------------
  logic [PW-1:0]        phase_one_r, phase_two_r;
  logic [PW-1:0]        step_one_r, step_two_r;
  logic signed [GW-1:0] gain_one_r, gain_two_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_one_r <= '0;
      phase_two_r <= '0;
      step_one_r  <= dsco_pkg::STEP_RST;
      step_two_r  <= dsco_pkg::STEP_RST;
      gain_one_r  <= dsco_pkg::GAIN_RST;
      gain_two_r  <= dsco_pkg::GAIN_RST;
    end else begin
      if (tick_acc) begin
        phase_one_r <= phase_one_r + step_one_r;
        phase_two_r <= phase_two_r + step_two_r;
      end
      if (axis_acc) begin
        case (in_chan.axis_number)
          dsco_pkg::AXIS_STEP_ONE: step_one_r <= axis_step;
          dsco_pkg::AXIS_STEP_TWO: step_two_r <= axis_step;
          dsco_pkg::AXIS_GAIN_ONE: gain_one_r <= axis_gain;
          dsco_pkg::AXIS_GAIN_TWO: gain_two_r <= axis_gain;
          default: ;
        endcase
      end
    end
  end

  // ---- stage 1: snapshot gains; phase_*_r is the tick's phase --------------
  // phases only move on a tick accept, which also loads this stage, so
  // phase_*_r stays valid for as long as s1 holds its tick
  logic signed [GW-1:0] s1_gain_one_r, s1_gain_two_r;

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_gain_one_r <= gain_one_r;
      s1_gain_two_r <= gain_two_r;
    end
  end

  // ---- stage 2: quarter-wave ROM, registered read --------------------------
  logic [MAG_W-1:0] rom_tab [0:QUARTER];

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
    assign rom_tab[gi] = MAG_W'(dsco_pkg::quarter_sine(64'(gi), TABLE_ADDR_BITS,
                                                       OUT_BITS));
  end

  logic [TABLE_ADDR_BITS-1:0] addr_one, addr_two;
  logic [IDX_W-1:0]           idx_one, idx_two;

  assign addr_one = phase_one_r[PW-1 -: TABLE_ADDR_BITS];
  assign addr_two = phase_two_r[PW-1 -: TABLE_ADDR_BITS];

  // odd quadrants run the table backwards
  assign idx_one = addr_one[TABLE_ADDR_BITS-2]
                 ? IDX_W'(QUARTER) - {1'b0, addr_one[TABLE_ADDR_BITS-3:0]}
                 : {1'b0, addr_one[TABLE_ADDR_BITS-3:0]};
  assign idx_two = addr_two[TABLE_ADDR_BITS-2]
                 ? IDX_W'(QUARTER) - {1'b0, addr_two[TABLE_ADDR_BITS-3:0]}
                 : {1'b0, addr_two[TABLE_ADDR_BITS-3:0]};

  logic [MAG_W-1:0]     s2_mag_one_r, s2_mag_two_r;
  logic                 s2_neg_one_r, s2_neg_two_r;
  logic signed [GW-1:0] s2_gain_one_r, s2_gain_two_r;

  always_ff @(posedge clk) begin
    if (en2 && s1_vld_r) begin
      s2_mag_one_r  <= rom_tab[idx_one];
      s2_mag_two_r  <= rom_tab[idx_two];
      s2_neg_one_r  <= addr_one[TABLE_ADDR_BITS-1];
      s2_neg_two_r  <= addr_two[TABLE_ADDR_BITS-1];
      s2_gain_one_r <= s1_gain_one_r;
      s2_gain_two_r <= s1_gain_two_r;
    end
  end

  // ---- stage 3: gain multiply ----------------------------------------------
  logic signed [MAG_W:0]    word_one, word_two;
  logic signed [PROD_W-1:0] s3_prod_one_r, s3_prod_two_r;

  assign word_one = s2_neg_one_r ? -signed'({1'b0, s2_mag_one_r})
                                 :  signed'({1'b0, s2_mag_one_r});
  assign word_two = s2_neg_two_r ? -signed'({1'b0, s2_mag_two_r})
                                 :  signed'({1'b0, s2_mag_two_r});

  always_ff @(posedge clk) begin
    if (en3 && s2_vld_r) begin
      s3_prod_one_r <= PROD_W'(s2_gain_one_r) * PROD_W'(word_one);
      s3_prod_two_r <= PROD_W'(s2_gain_two_r) * PROD_W'(word_two);
    end
  end

  // ---- stage 4: round half up, floor shift, keep 16 bits --------------------
  logic signed [PROD_W:0] rnd_one, rnd_two;
  logic signed [PROD_W:0] shf_one, shf_two;
  logic signed [SW-1:0]   out_sample_one_r, out_sample_two_r;

  assign rnd_one = (PROD_W+1)'(s3_prod_one_r) + ((PROD_W+1)'(1) <<< (OUT_BITS - 2));
  assign rnd_two = (PROD_W+1)'(s3_prod_two_r) + ((PROD_W+1)'(1) <<< (OUT_BITS - 2));
  assign shf_one = rnd_one >>> (OUT_BITS - 1);
  assign shf_two = rnd_two >>> (OUT_BITS - 1);

  always_ff @(posedge clk) begin
    if (en_out && s3_vld_r) begin
      out_sample_one_r <= shf_one[SW-1:0];
      out_sample_two_r <= shf_two[SW-1:0];
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.sample_one = out_sample_one_r;
  assign out_chan.sample_two = out_sample_two_r;

  // ---- stage valids --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1)    s1_vld_r  <= tick_acc;
      if (en2)    s2_vld_r  <= s1_vld_r;
      if (en3)    s3_vld_r  <= s2_vld_r;
      if (en_out) out_vld_r <= s3_vld_r;
    end
  end

  // ---- assertions ------------------------------------------------------------
  logic [2*PW-1:0] phases;
  logic            stall_full;

  assign phases     = {phase_one_r, phase_two_r};
  assign stall_full = s1_vld_r && s2_vld_r && s3_vld_r && out_vld_r && !out_chan.ready;

  `DSCO_ASSERT_NEXT(a_tick_enters, tick_acc, s1_vld_r, "tick not loaded into stage 1")
  `DSCO_ASSERT_NEXT(a_axis_keeps_phase, axis_acc, $stable(phases), "axis item moved a phase")
  `DSCO_ASSERT_NOW(a_full_stalls, stall_full, !in_chan.ready, "input taken while full")
  `DSCO_ASSERT_NEXT(a_drain_to_out, s3_vld_r && en_out, out_vld_r, "stage 3 result lost")

endmodule

`default_nettype wire
